### rtl/hptc_pkg.sv
// shared types, opcodes and the compensation microprogram
package hptc_pkg;

    localparam int PC_W = 7;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_RSUB  = 4'd2;
    localparam logic [3:0] OP_SHL   = 4'd3;
    localparam logic [3:0] OP_SDIV  = 4'd4;
    localparam logic [3:0] OP_W32   = 4'd5;
    localparam logic [3:0] OP_MUL   = 4'd6;
    localparam logic [3:0] OP_DIV   = 4'd7;
    localparam logic [3:0] OP_SAT   = 4'd8;
    localparam logic [3:0] OP_CLMP  = 4'd9;
    localparam logic [3:0] OP_BRZ   = 4'd10;
    localparam logic [3:0] OP_WFINE = 4'd11;
    localparam logic [3:0] OP_WT    = 4'd12;
    localparam logic [3:0] OP_WP    = 4'd13;
    localparam logic [3:0] OP_WH    = 4'd14;
    localparam logic [3:0] OP_END   = 4'd15;

    localparam logic [4:0] S_R0   = 5'd0;
    localparam logic [4:0] S_R1   = 5'd1;
    localparam logic [4:0] S_R2   = 5'd2;
    localparam logic [4:0] S_R3   = 5'd3;
    localparam logic [4:0] S_R4   = 5'd4;
    localparam logic [4:0] S_R5   = 5'd5;
    localparam logic [4:0] S_R6   = 5'd6;
    localparam logic [4:0] S_R7   = 5'd7;
    localparam logic [4:0] S_IMM  = 5'd8;
    localparam logic [4:0] S_T1   = 5'd9;
    localparam logic [4:0] S_T2   = 5'd10;
    localparam logic [4:0] S_T3   = 5'd11;
    localparam logic [4:0] S_P1   = 5'd12;
    localparam logic [4:0] S_P2   = 5'd13;
    localparam logic [4:0] S_P3   = 5'd14;
    localparam logic [4:0] S_P4   = 5'd15;
    localparam logic [4:0] S_P5   = 5'd16;
    localparam logic [4:0] S_P6   = 5'd17;
    localparam logic [4:0] S_P7   = 5'd18;
    localparam logic [4:0] S_P8   = 5'd19;
    localparam logic [4:0] S_P9   = 5'd20;
    localparam logic [4:0] S_H1   = 5'd21;
    localparam logic [4:0] S_H2   = 5'd22;
    localparam logic [4:0] S_H3   = 5'd23;
    localparam logic [4:0] S_H4   = 5'd24;
    localparam logic [4:0] S_H5   = 5'd25;
    localparam logic [4:0] S_H6   = 5'd26;
    localparam logic [4:0] S_ADCT = 5'd27;
    localparam logic [4:0] S_ADCP = 5'd28;
    localparam logic [4:0] S_RAWH = 5'd29;
    localparam logic [4:0] S_FINE = 5'd30;
    localparam logic [4:0] S_OFF  = 5'd31;

    localparam logic [PC_W-1:0] PC_TEMP  = 7'd0;
    localparam logic [PC_W-1:0] PC_PRESS = 7'd26;
    localparam logic [PC_W-1:0] PC_PZERO = 7'd62;
    localparam logic [PC_W-1:0] PC_HUM   = 7'd64;

    localparam logic [63:0] SEC_TEMP  = 64'd0;
    localparam logic [63:0] SEC_PRESS = 64'd1;
    localparam logic [63:0] SEC_HUM   = 64'd2;

    localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
    localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
    localparam logic [2:0] REG_CAL_HUM_A   = 3'd4;
    localparam logic [2:0] REG_CAL_HUM_B   = 3'd5;
    localparam logic [2:0] REG_FINE_OFFSET = 3'd6;

    typedef struct packed {
        logic [3:0]  op;
        logic [2:0]  dst;
        logic [4:0]  sa;
        logic [4:0]  sb;
        logic [63:0] imm;
    } instr_t;

    typedef struct packed {
        logic start;
        logic div;
    } md_req_t;

    typedef struct packed {
        logic done;
    } md_stat_t;

    function automatic instr_t mk(logic [3:0] op, logic [2:0] dst, logic [4:0] sa,
                                  logic [4:0] sb, logic [63:0] imm);
        instr_t i;
        i.op  = op;
        i.dst = dst;
        i.sa  = sa;
        i.sb  = sb;
        i.imm = imm;
        return i;
    endfunction

    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t i;
        case (pc)
            // temperature
            7'd0:   i = mk(OP_SDIV,  3'd0, S_ADCT, S_IMM, 64'd3);
            7'd1:   i = mk(OP_SHL,   3'd1, S_T1,   S_IMM, 64'd1);
            7'd2:   i = mk(OP_SUB,   3'd0, S_R0,   S_R1,  64'd0);
            7'd3:   i = mk(OP_MUL,   3'd0, S_R0,   S_T2,  64'd0);
            7'd4:   i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd5:   i = mk(OP_SDIV,  3'd0, S_R0,   S_IMM, 64'd11);
            7'd6:   i = mk(OP_SDIV,  3'd1, S_ADCT, S_IMM, 64'd4);
            7'd7:   i = mk(OP_SUB,   3'd1, S_R1,   S_T1,  64'd0);
            7'd8:   i = mk(OP_MUL,   3'd1, S_R1,   S_R1,  64'd0);
            7'd9:   i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd10:  i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd12);
            7'd11:  i = mk(OP_MUL,   3'd1, S_R1,   S_T3,  64'd0);
            7'd12:  i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd13:  i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd14);
            7'd14:  i = mk(OP_ADD,   3'd0, S_R0,   S_R1,  64'd0);
            7'd15:  i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd16:  i = mk(OP_ADD,   3'd0, S_R0,   S_OFF, 64'd0);
            7'd17:  i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd18:  i = mk(OP_WFINE, 3'd0, S_R0,   S_IMM, 64'd0);
            7'd19:  i = mk(OP_MUL,   3'd0, S_R0,   S_IMM, 64'd5);
            7'd20:  i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd21:  i = mk(OP_ADD,   3'd0, S_R0,   S_IMM, 64'd128);
            7'd22:  i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd23:  i = mk(OP_SDIV,  3'd0, S_R0,   S_IMM, 64'd8);
            7'd24:  i = mk(OP_WT,    3'd0, S_R0,   S_IMM, 64'd0);
            7'd25:  i = mk(OP_END,   3'd0, S_R0,   S_IMM, SEC_TEMP);
            // pressure
            7'd26:  i = mk(OP_SUB,   3'd0, S_FINE, S_IMM, 64'd128000);
            7'd27:  i = mk(OP_MUL,   3'd1, S_R0,   S_R0,  64'd0);
            7'd28:  i = mk(OP_MUL,   3'd2, S_R1,   S_P6,  64'd0);
            7'd29:  i = mk(OP_MUL,   3'd3, S_R0,   S_P5,  64'd0);
            7'd30:  i = mk(OP_SHL,   3'd3, S_R3,   S_IMM, 64'd17);
            7'd31:  i = mk(OP_ADD,   3'd2, S_R2,   S_R3,  64'd0);
            7'd32:  i = mk(OP_SHL,   3'd3, S_P4,   S_IMM, 64'd35);
            7'd33:  i = mk(OP_ADD,   3'd2, S_R2,   S_R3,  64'd0);
            7'd34:  i = mk(OP_MUL,   3'd1, S_R1,   S_P3,  64'd0);
            7'd35:  i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd8);
            7'd36:  i = mk(OP_MUL,   3'd3, S_R0,   S_P2,  64'd0);
            7'd37:  i = mk(OP_SHL,   3'd3, S_R3,   S_IMM, 64'd12);
            7'd38:  i = mk(OP_ADD,   3'd1, S_R1,   S_R3,  64'd0);
            7'd39:  i = mk(OP_ADD,   3'd1, S_R1,   S_IMM, 64'd140737488355328);
            7'd40:  i = mk(OP_MUL,   3'd1, S_R1,   S_P1,  64'd0);
            7'd41:  i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd33);
            7'd42:  i = mk(OP_BRZ,   3'd0, S_R1,   S_IMM, {57'd0, PC_PZERO});
            7'd43:  i = mk(OP_RSUB,  3'd0, S_ADCP, S_IMM, 64'd1048576);
            7'd44:  i = mk(OP_SHL,   3'd0, S_R0,   S_IMM, 64'd31);
            7'd45:  i = mk(OP_SUB,   3'd0, S_R0,   S_R2,  64'd0);
            7'd46:  i = mk(OP_MUL,   3'd0, S_R0,   S_IMM, 64'd3125);
            7'd47:  i = mk(OP_DIV,   3'd0, S_R0,   S_R1,  64'd0);
            7'd48:  i = mk(OP_SDIV,  3'd3, S_R0,   S_IMM, 64'd13);
            7'd49:  i = mk(OP_MUL,   3'd4, S_P9,   S_R3,  64'd0);
            7'd50:  i = mk(OP_MUL,   3'd4, S_R4,   S_R3,  64'd0);
            7'd51:  i = mk(OP_SDIV,  3'd4, S_R4,   S_IMM, 64'd25);
            7'd52:  i = mk(OP_MUL,   3'd5, S_P8,   S_R0,  64'd0);
            7'd53:  i = mk(OP_SDIV,  3'd5, S_R5,   S_IMM, 64'd19);
            7'd54:  i = mk(OP_ADD,   3'd0, S_R0,   S_R4,  64'd0);
            7'd55:  i = mk(OP_ADD,   3'd0, S_R0,   S_R5,  64'd0);
            7'd56:  i = mk(OP_SDIV,  3'd0, S_R0,   S_IMM, 64'd8);
            7'd57:  i = mk(OP_SHL,   3'd6, S_P7,   S_IMM, 64'd4);
            7'd58:  i = mk(OP_ADD,   3'd0, S_R0,   S_R6,  64'd0);
            7'd59:  i = mk(OP_SAT,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd60:  i = mk(OP_WP,    3'd0, S_R0,   S_IMM, 64'd0);
            7'd61:  i = mk(OP_END,   3'd0, S_R0,   S_IMM, SEC_PRESS);
            7'd62:  i = mk(OP_WP,    3'd0, S_IMM,  S_IMM, 64'd0);
            7'd63:  i = mk(OP_END,   3'd0, S_R0,   S_IMM, SEC_PRESS);
            // humidity
            7'd64:  i = mk(OP_SUB,   3'd0, S_FINE, S_IMM, 64'd76800);
            7'd65:  i = mk(OP_W32,   3'd0, S_R0,   S_IMM, 64'd0);
            7'd66:  i = mk(OP_SHL,   3'd1, S_RAWH, S_IMM, 64'd14);
            7'd67:  i = mk(OP_SHL,   3'd2, S_H4,   S_IMM, 64'd20);
            7'd68:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd69:  i = mk(OP_MUL,   3'd3, S_H5,   S_R0,  64'd0);
            7'd70:  i = mk(OP_W32,   3'd3, S_R3,   S_IMM, 64'd0);
            7'd71:  i = mk(OP_SUB,   3'd1, S_R1,   S_R2,  64'd0);
            7'd72:  i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd73:  i = mk(OP_SUB,   3'd1, S_R1,   S_R3,  64'd0);
            7'd74:  i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd75:  i = mk(OP_ADD,   3'd1, S_R1,   S_IMM, 64'd16384);
            7'd76:  i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd77:  i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd15);
            7'd78:  i = mk(OP_MUL,   3'd2, S_R0,   S_H6,  64'd0);
            7'd79:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd80:  i = mk(OP_SDIV,  3'd2, S_R2,   S_IMM, 64'd10);
            7'd81:  i = mk(OP_MUL,   3'd3, S_R0,   S_H3,  64'd0);
            7'd82:  i = mk(OP_W32,   3'd3, S_R3,   S_IMM, 64'd0);
            7'd83:  i = mk(OP_SDIV,  3'd3, S_R3,   S_IMM, 64'd11);
            7'd84:  i = mk(OP_ADD,   3'd3, S_R3,   S_IMM, 64'd32768);
            7'd85:  i = mk(OP_W32,   3'd3, S_R3,   S_IMM, 64'd0);
            7'd86:  i = mk(OP_MUL,   3'd2, S_R2,   S_R3,  64'd0);
            7'd87:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd88:  i = mk(OP_SDIV,  3'd2, S_R2,   S_IMM, 64'd10);
            7'd89:  i = mk(OP_ADD,   3'd2, S_R2,   S_IMM, 64'd2097152);
            7'd90:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd91:  i = mk(OP_MUL,   3'd2, S_R2,   S_H2,  64'd0);
            7'd92:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd93:  i = mk(OP_ADD,   3'd2, S_R2,   S_IMM, 64'd8192);
            7'd94:  i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd95:  i = mk(OP_SDIV,  3'd2, S_R2,   S_IMM, 64'd14);
            7'd96:  i = mk(OP_MUL,   3'd1, S_R1,   S_R2,  64'd0);
            7'd97:  i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd98:  i = mk(OP_SDIV,  3'd2, S_R1,   S_IMM, 64'd15);
            7'd99:  i = mk(OP_MUL,   3'd2, S_R2,   S_R2,  64'd0);
            7'd100: i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd101: i = mk(OP_SDIV,  3'd2, S_R2,   S_IMM, 64'd7);
            7'd102: i = mk(OP_MUL,   3'd2, S_R2,   S_H1,  64'd0);
            7'd103: i = mk(OP_W32,   3'd2, S_R2,   S_IMM, 64'd0);
            7'd104: i = mk(OP_SDIV,  3'd2, S_R2,   S_IMM, 64'd4);
            7'd105: i = mk(OP_SUB,   3'd1, S_R1,   S_R2,  64'd0);
            7'd106: i = mk(OP_W32,   3'd1, S_R1,   S_IMM, 64'd0);
            7'd107: i = mk(OP_CLMP,  3'd1, S_R1,   S_IMM, 64'd0);
            7'd108: i = mk(OP_SDIV,  3'd1, S_R1,   S_IMM, 64'd12);
            7'd109: i = mk(OP_WH,    3'd0, S_R1,   S_IMM, 64'd0);
            default: i = mk(OP_END,  3'd0, S_R0,   S_IMM, SEC_HUM);
        endcase
        return i;
    endfunction

endpackage

### rtl/hptc_muldiv.sv
// shared serial unit: 64-bit wrapping multiply and truncating signed divide
module hptc_muldiv import hptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  md_req_t     req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output md_stat_t    stat,
    output logic [63:0] result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [64:0] acc_reg, acc_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [64:0] shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        shifted   = {acc_reg[63:0], x_reg[63]};
        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.div;
            neg_next  = a[63] ^ b[63];
            acc_next  = '0;
            cnt_next  = '0;
            if (req.div) begin
                x_next = a[63] ? (64'd0 - a) : a;
                y_next = b[63] ? (64'd0 - b) : b;
            end else begin
                x_next = a;
                y_next = b;
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (shifted >= {1'b0, y_reg}) begin
                    acc_next = shifted - {1'b0, y_reg};
                    x_next   = {x_reg[62:0], 1'b1};
                end else begin
                    acc_next = shifted;
                    x_next   = {x_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else if (y_reg == 64'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                acc_next = {1'b0, acc_reg[63:0] + (y_reg[0] ? x_reg : 64'd0)};
                x_next   = {x_reg[62:0], 1'b0};
                y_next   = {1'b0, y_reg[63:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    assign stat.done = done_reg;
    assign result = div_reg ? (neg_reg ? (64'd0 - x_reg) : x_reg) : acc_reg[63:0];

endmodule

### rtl/humidity_pressure_temp_compensation_core.sv
// top level: sequencer, register file and config for sensor compensation
//
// s_axis carries one raw reading per beat: temperature, pressure and
// humidity packed in s_tdata. s_tready is high only while the core is idle;
// one beat is then worked through a microprogram of about 110 steps over a
// single 64-bit serial multiply/divide unit, on which every multiply and
// divide step waits; a disabled temperature or pressure reading skips
// its section, and so does a disabled humidity reading unless all are off.
// m_axis gives one beat per input: compensated values in m_tdata and the
// three valid flags in m_tuser. The result sits in an output register; if
// the receiver stalls, the next reading is still accepted and computed, and
// the sequencer holds at its last step until the output register frees.
// The cfg channel writes calibration registers and is always ready; write
// it only while idle. aresetn (synchronous, active low) clears calibration,
// the stored fine temperature and all handshake state.
module humidity_pressure_temp_compensation_core import hptc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // raw_temperature[23:0], raw_pressure[47:24], raw_humidity[63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // temp_centi[31:0], press_q24_8[63:32], hum_q7_10[80:64], zero pad
    output logic [87:0] m_tdata,
    // temp_valid[0], press_valid[1], hum_valid[2]
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic            state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            wait_reg, wait_next;
    logic [63:0]     rf_reg [8];
    logic [47:0]     cal_t_reg;
    logic [63:0]     cal_pa_reg, cal_pb_reg;
    logic [15:0]     cal_pc_reg;
    logic [39:0]     cal_ha_reg;
    logic [23:0]     cal_hb_reg;
    logic [31:0]     off_reg;
    logic [31:0]     fine_reg;
    logic [23:0]     raw_t_reg, raw_p_reg;
    logic [15:0]     raw_h_reg;
    logic [2:0]      flags_reg;
    logic [31:0]     t_res_reg, p_res_reg;
    logic [16:0]     h_res_reg;
    logic            out_valid_reg;
    logic [87:0]     out_data_reg;
    logic [2:0]      out_user_reg;

    instr_t          ins;
    logic [63:0]     a_val, b_val, alu;
    logic            wr_en;
    md_req_t         md_req;
    md_stat_t        md_stat;
    logic [63:0]     md_res;
    logic            accept, finish;
    logic            pv, hv;
    logic [PC_W-1:0] nxt_sec_pc;
    logic            nxt_sec_done;
    logic [63:0]     bias;

    function automatic logic [63:0] src(
        logic [4:0] s, logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
        logic [63:0] r3, logic [63:0] r4, logic [63:0] r5, logic [63:0] r6,
        logic [63:0] r7, logic [63:0] imm, logic [47:0] ct, logic [63:0] pa,
        logic [63:0] pb, logic [15:0] pc, logic [39:0] ha, logic [23:0] hb,
        logic [23:0] rt, logic [23:0] rp, logic [15:0] rh, logic [31:0] fine,
        logic [31:0] off);
        logic [63:0] v;
        case (s)
            S_R0:   v = r0;
            S_R1:   v = r1;
            S_R2:   v = r2;
            S_R3:   v = r3;
            S_R4:   v = r4;
            S_R5:   v = r5;
            S_R6:   v = r6;
            S_R7:   v = r7;
            S_IMM:  v = imm;
            S_T1:   v = {48'd0, ct[15:0]};
            S_T2:   v = {{48{ct[31]}}, ct[31:16]};
            S_T3:   v = {{48{ct[47]}}, ct[47:32]};
            S_P1:   v = {48'd0, pa[15:0]};
            S_P2:   v = {{48{pa[31]}}, pa[31:16]};
            S_P3:   v = {{48{pa[47]}}, pa[47:32]};
            S_P4:   v = {{48{pa[63]}}, pa[63:48]};
            S_P5:   v = {{48{pb[15]}}, pb[15:0]};
            S_P6:   v = {{48{pb[31]}}, pb[31:16]};
            S_P7:   v = {{48{pb[47]}}, pb[47:32]};
            S_P8:   v = {{48{pb[63]}}, pb[63:48]};
            S_P9:   v = {{48{pc[15]}}, pc[15:0]};
            S_H1:   v = {56'd0, ha[7:0]};
            S_H2:   v = {{48{ha[23]}}, ha[23:8]};
            S_H3:   v = {56'd0, ha[31:24]};
            S_H6:   v = {{56{ha[39]}}, ha[39:32]};
            S_H4:   v = {{52{hb[11]}}, hb[11:0]};
            S_H5:   v = {{52{hb[23]}}, hb[23:12]};
            S_ADCT: v = {44'd0, rt[23:4]};
            S_ADCP: v = {44'd0, rp[23:4]};
            S_RAWH: v = {48'd0, rh};
            S_FINE: v = {{32{fine[31]}}, fine};
            S_OFF:  v = {{32{off[31]}}, off};
            default: v = r0;
        endcase
        return v;
    endfunction

    assign ins = prog(pc_reg);
    assign a_val = src(ins.sa, rf_reg[0], rf_reg[1], rf_reg[2], rf_reg[3], rf_reg[4],
                       rf_reg[5], rf_reg[6], rf_reg[7], ins.imm, cal_t_reg, cal_pa_reg,
                       cal_pb_reg, cal_pc_reg, cal_ha_reg, cal_hb_reg, raw_t_reg,
                       raw_p_reg, raw_h_reg, fine_reg, off_reg);
    assign b_val = src(ins.sb, rf_reg[0], rf_reg[1], rf_reg[2], rf_reg[3], rf_reg[4],
                       rf_reg[5], rf_reg[6], rf_reg[7], ins.imm, cal_t_reg, cal_pa_reg,
                       cal_pb_reg, cal_pc_reg, cal_ha_reg, cal_hb_reg, raw_t_reg,
                       raw_p_reg, raw_h_reg, fine_reg, off_reg);

    assign bias = a_val[63] ? ((64'd1 << ins.imm[5:0]) - 64'd1) : 64'd0;

    always_comb begin
        case (ins.op)
            OP_ADD:  alu = a_val + b_val;
            OP_SUB:  alu = a_val - b_val;
            OP_RSUB: alu = b_val - a_val;
            OP_SHL:  alu = a_val << ins.imm[5:0];
            OP_SDIV: alu = $signed(a_val + bias) >>> ins.imm[5:0];
            OP_W32:  alu = {{32{a_val[31]}}, a_val[31:0]};
            OP_SAT: begin
                if ($signed(a_val) > $signed(64'sd2147483647)) begin
                    alu = 64'd2147483647;
                end else if ($signed(a_val) < $signed(-64'sd2147483648)) begin
                    alu = {{33{1'b1}}, 31'd0};
                end else begin
                    alu = a_val;
                end
            end
            OP_CLMP: begin
                if (a_val[63]) begin
                    alu = 64'd0;
                end else if (a_val > 64'd419430400) begin
                    alu = 64'd419430400;
                end else begin
                    alu = a_val;
                end
            end
            OP_MUL, OP_DIV: alu = md_res;
            default: alu = a_val;
        endcase
    end

    assign pv = flags_reg[1];
    assign hv = flags_reg[2];

    always_comb begin
        nxt_sec_done = 1'b0;
        nxt_sec_pc   = PC_HUM;
        if (ins.imm == SEC_TEMP && pv) begin
            nxt_sec_pc = PC_PRESS;
        end else if (ins.imm != SEC_HUM && hv) begin
            nxt_sec_pc = PC_HUM;
        end else begin
            nxt_sec_done = 1'b1;
        end
    end

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign finish    = (state_reg == ST_RUN) && (ins.op == OP_END) && nxt_sec_done &&
                       (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        wait_next  = wait_reg;
        wr_en      = 1'b0;
        md_req     = '0;
        if (state_reg == ST_IDLE) begin
            if (accept) begin
                state_next = ST_RUN;
                if (s_tdata[23:0] != 24'h800000) begin
                    pc_next = PC_TEMP;
                end else if (s_tdata[47:24] != 24'h800000) begin
                    pc_next = PC_PRESS;
                end else begin
                    // with only humidity or nothing enabled the humidity
                    // section runs; its end step handles the empty case
                    pc_next = PC_HUM;
                end
            end
        end else begin
            case (ins.op)
                OP_MUL, OP_DIV: begin
                    if (!wait_reg) begin
                        md_req.start = 1'b1;
                        md_req.div   = (ins.op == OP_DIV);
                        wait_next    = 1'b1;
                    end else if (md_stat.done) begin
                        wr_en     = 1'b1;
                        wait_next = 1'b0;
                        pc_next   = pc_reg + PC_W'(1);
                    end
                end
                OP_BRZ: begin
                    pc_next = (a_val == 64'd0) ? ins.imm[PC_W-1:0] : pc_reg + PC_W'(1);
                end
                OP_END: begin
                    if (!nxt_sec_done) begin
                        pc_next = nxt_sec_pc;
                    end else if (finish) begin
                        state_next = ST_IDLE;
                    end
                end
                OP_ADD, OP_SUB, OP_RSUB, OP_SHL, OP_SDIV, OP_W32, OP_SAT, OP_CLMP: begin
                    wr_en   = 1'b1;
                    pc_next = pc_reg + PC_W'(1);
                end
                default: begin
                    pc_next = pc_reg + PC_W'(1);
                end
            endcase
        end
    end

    hptc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .a       (a_val),
        .b       (b_val),
        .stat    (md_stat),
        .result  (md_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fine_reg      <= '0;
            cal_t_reg     <= '0;
            cal_pa_reg    <= '0;
            cal_pb_reg    <= '0;
            cal_pc_reg    <= '0;
            cal_ha_reg    <= '0;
            cal_hb_reg    <= '0;
            off_reg       <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            wait_reg  <= wait_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_RUN && ins.op == OP_WFINE) begin
                fine_reg <= a_val[31:0];
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_CAL_TEMP:    cal_t_reg  <= cfg_data[47:0];
                    REG_CAL_PRESS_A: cal_pa_reg <= cfg_data;
                    REG_CAL_PRESS_B: cal_pb_reg <= cfg_data;
                    REG_CAL_PRESS_C: cal_pc_reg <= cfg_data[15:0];
                    REG_CAL_HUM_A:   cal_ha_reg <= cfg_data[39:0];
                    REG_CAL_HUM_B:   cal_hb_reg <= cfg_data[23:0];
                    REG_FINE_OFFSET: off_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
        if (accept) begin
            raw_t_reg <= s_tdata[23:0];
            raw_p_reg <= s_tdata[47:24];
            raw_h_reg <= s_tdata[63:48];
            flags_reg <= {s_tdata[63:48] != 16'h8000, s_tdata[47:24] != 24'h800000,
                          s_tdata[23:0] != 24'h800000};
            t_res_reg <= '0;
            p_res_reg <= '0;
            h_res_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            // humidity section entered with humidity disabled writes nothing
            if (ins.op == OP_WT) begin
                t_res_reg <= a_val[31:0];
            end
            if (ins.op == OP_WP) begin
                p_res_reg <= a_val[31:0];
            end
            if (ins.op == OP_WH && hv) begin
                h_res_reg <= a_val[16:0];
            end
        end
        if (wr_en) begin
            rf_reg[ins.dst] <= alu;
        end
        if (finish) begin
            out_data_reg <= {7'd0, h_res_reg, p_res_reg, t_res_reg};
            out_user_reg <= flags_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
